/* hw/rtl/utf8_punctuation_normalizer_unit_defines.svh */
// Assertion macros shared by the punctuation normalizer RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef UTF8_PUNCTUATION_NORMALIZER_UNIT_DEFINES_SVH
`define UTF8_PUNCTUATION_NORMALIZER_UNIT_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define UPN_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define UPN_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define UPN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/upn_pkg.sv */
// Types, constants and helper functions of the UTF-8 punctuation normalizer.
// Used by upn_core, upn_outq and the top level; depends on nothing else.
package upn_pkg;

  typedef enum logic [1:0] {
    HQ_NONE,
    HQ_APOS,
    HQ_TICK
  } held_e;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;

  localparam logic [10:0] CP_NBSP   = 11'h0A0;
  localparam logic [15:0] CP_LSQUO  = 16'h2018;
  localparam logic [15:0] CP_RSQUO  = 16'h2019;
  localparam logic [15:0] CP_PRIME  = 16'h2032;
  localparam logic [15:0] CP_LDQUO  = 16'h201C;
  localparam logic [15:0] CP_RDQUO  = 16'h201D;
  localparam logic [15:0] CP_ENDASH = 16'h2013;
  localparam logic [15:0] CP_EMDASH = 16'h2014;
  localparam logic [15:0] CP_ELLIP  = 16'h2026;
  localparam logic [15:0] CP_SHY    = 16'h00AD;

  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_TICK   = 8'h60;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [2:0] RES_MAX = 3'd4;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } grp_t;

  typedef struct packed {
    res_t  res;
    held_e held;
  } fold_t;

  function automatic res_t push(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (r.cnt < RES_MAX) begin
      o.bytes[r.cnt[1:0]] = b;
      o.cnt = r.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic fold_t flush(fold_t s);
    fold_t r;
    r = s;
    if (s.held == HQ_APOS) begin
      r.res = push(r.res, CH_APOS);
    end else if (s.held == HQ_TICK) begin
      r.res = push(r.res, CH_TICK);
    end
    r.held = HQ_NONE;
    return r;
  endfunction

  function automatic fold_t fold(fold_t s, logic [7:0] b);
    fold_t r;
    r = s;
    if (b == CH_APOS && s.held == HQ_APOS) begin
      r.held = HQ_NONE;
      r.res = push(r.res, CH_DQUOTE);
    end else if (b == CH_TICK && s.held == HQ_TICK) begin
      r.held = HQ_NONE;
      r.res = push(r.res, CH_DQUOTE);
    end else begin
      r = flush(r);
      if (b == CH_APOS) begin
        r.held = HQ_APOS;
      end else if (b == CH_TICK) begin
        r.held = HQ_TICK;
      end else begin
        r.res = push(r.res, b);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/upn_core.sv */
// Sequence decoder, punctuation mapping and quote folding with their state.
// Depends on upn_pkg and the shared assertion macro header.
`include "utf8_punctuation_normalizer_unit_defines.svh"

module upn_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output upn_pkg::grp_t grp_o
);

  logic [7:0]     pf_q, pf_d;
  logic [7:0]     ps_q, ps_d;
  logic [1:0]     pend_cnt_q, pend_cnt_d;
  logic           triple_q, triple_d;
  upn_pkg::held_e held_q, held_d;

  logic [2:0][7:0] m;
  logic [1:0]      mcnt;
  logic [10:0]     cp2;
  logic [15:0]     cp3;
  upn_pkg::fold_t  st;

  assign cp2 = {pf_q[4:0], in_byte_i[5:0]};
  assign cp3 = {pf_q[3:0], ps_q[5:0], in_byte_i[5:0]};

  always_comb begin
    m          = '0;
    mcnt       = 2'd0;
    pf_d       = pf_q;
    ps_d       = ps_q;
    pend_cnt_d = pend_cnt_q;
    triple_d   = triple_q;
    priority if (pend_cnt_q == 2'd0) begin
      if (!in_byte_i[7]) begin
        m[0] = in_byte_i;
        mcnt = 2'd1;
      end else if ((in_byte_i & upn_pkg::LEAD2_MASK) == upn_pkg::LEAD2_VAL && !in_last_i) begin
        pf_d       = in_byte_i;
        pend_cnt_d = 2'd1;
        triple_d   = 1'b0;
      end else if ((in_byte_i & upn_pkg::LEAD3_MASK) == upn_pkg::LEAD3_VAL && !in_last_i) begin
        pf_d       = in_byte_i;
        pend_cnt_d = 2'd1;
        triple_d   = 1'b1;
      end else begin
        m[0] = in_byte_i;
        mcnt = 2'd1;
      end
    end else if (pend_cnt_q == 2'd1 && !triple_q) begin
      if (cp2 == upn_pkg::CP_NBSP) begin
        m[0] = upn_pkg::CH_SPACE;
        mcnt = 2'd1;
      end else begin
        m[0] = pf_q;
        m[1] = in_byte_i;
        mcnt = 2'd2;
      end
      pend_cnt_d = 2'd0;
    end else if (pend_cnt_q == 2'd1) begin
      if (in_last_i) begin
        m[0]       = pf_q;
        m[1]       = in_byte_i;
        mcnt       = 2'd2;
        pend_cnt_d = 2'd0;
      end else begin
        ps_d       = in_byte_i;
        pend_cnt_d = 2'd2;
      end
    end else begin
      if (cp3 == upn_pkg::CP_LSQUO || cp3 == upn_pkg::CP_RSQUO ||
          cp3 == upn_pkg::CP_PRIME) begin
        m[0] = upn_pkg::CH_APOS;
        mcnt = 2'd1;
      end else if (cp3 == upn_pkg::CP_LDQUO || cp3 == upn_pkg::CP_RDQUO) begin
        m[0] = upn_pkg::CH_DQUOTE;
        mcnt = 2'd1;
      end else if (cp3 == upn_pkg::CP_ENDASH || cp3 == upn_pkg::CP_EMDASH) begin
        m[0] = upn_pkg::CH_SPACE;
        m[1] = upn_pkg::CH_HYPHEN;
        m[2] = upn_pkg::CH_SPACE;
        mcnt = 2'd3;
      end else if (cp3 == upn_pkg::CP_ELLIP) begin
        m[0] = upn_pkg::CH_DOT;
        m[1] = upn_pkg::CH_DOT;
        m[2] = upn_pkg::CH_DOT;
        mcnt = 2'd3;
      end else if (cp3 == upn_pkg::CP_SHY) begin
        mcnt = 2'd0;
      end else begin
        m[0] = pf_q;
        m[1] = ps_q;
        m[2] = in_byte_i;
        mcnt = 2'd3;
      end
      pend_cnt_d = 2'd0;
    end

    st.res  = '0;
    st.held = held_q;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < mcnt) begin
        st = upn_pkg::fold(st, m[i]);
      end
    end
    if (in_last_i) begin
      st         = upn_pkg::flush(st);
      pend_cnt_d = 2'd0;
    end
    if (pend_cnt_d == 2'd0) begin
      pf_d     = '0;
      ps_d     = '0;
      triple_d = 1'b0;
    end
    held_d = st.held;
  end

  assign grp_o.res  = st.res;
  assign grp_o.last = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pf_q       <= '0;
      ps_q       <= '0;
      pend_cnt_q <= 2'd0;
      triple_q   <= 1'b0;
      held_q     <= upn_pkg::HQ_NONE;
    end else if (adv_i) begin
      pf_q       <= pf_d;
      ps_q       <= ps_d;
      pend_cnt_q <= pend_cnt_d;
      triple_q   <= triple_d;
      held_q     <= held_d;
    end
  end

  `UPN_ASSERT_ALWAYS(a_pend_cnt_range, pend_cnt_q != 2'd3, "pending count out of range")
  `UPN_ASSERT_NEXT(a_end_clears, adv_i && in_last_i, pend_cnt_q == 2'd0 && held_q == upn_pkg::HQ_NONE, "state not cleared after end of text")
  `UPN_ASSERT_NEXT(a_triple_done, adv_i && pend_cnt_q == 2'd2, pend_cnt_q == 2'd0, "three-byte sequence not closed")

endmodule

/* hw/rtl/upn_outq.sv */
// Result group register that hands out one beat per cycle on the master side while m_axis_tready_i is high.
// Depends on upn_pkg and the shared assertion macro header.
`include "utf8_punctuation_normalizer_unit_defines.svh"

module upn_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  upn_pkg::grp_t grp_i,
  output logic          free_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,
  output logic [1:0]    m_axis_tuser_o,
  output logic          m_axis_tlast_o
);

  logic            valid_q, valid_d;
  logic [3:0][7:0] bytes_q, bytes_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  logic            empty_q, empty_d;
  logic            last_q, last_d;
  logic            last_beat;
  logic            take;
  logic            load;

  assign last_beat = ({1'b0, idx_q} + 3'd1) == cnt_q;
  assign take      = valid_q && m_axis_tready_i;
  assign free_o    = !valid_q || (m_axis_tready_i && last_beat);
  assign load      = adv_i && (grp_i.res.cnt != 3'd0 || grp_i.last);

  always_comb begin
    valid_d = valid_q;
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    empty_d = empty_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      bytes_d = grp_i.res.bytes;
      empty_d = grp_i.res.cnt == 3'd0;
      cnt_d   = (grp_i.res.cnt == 3'd0) ? 3'd1 : grp_i.res.cnt;
      last_d  = grp_i.last;
      idx_d   = 2'd0;
    end else if (take && last_beat) begin
      valid_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd1;
      idx_q   <= 2'd0;
      empty_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      empty_q <= empty_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = empty_q ? 8'h00 : bytes_q[idx_q];
  assign m_axis_tlast_o  = last_beat;
  assign m_axis_tuser_o  = {last_beat && last_q, !empty_q};

  `UPN_ASSERT_IMPLIES(a_cnt_nonzero, valid_q, cnt_q != 3'd0, "group with no beats")
  `UPN_ASSERT_IMPLIES(a_idx_in_range, valid_q, {1'b0, idx_q} < cnt_q, "beat index past group end")
  `UPN_ASSERT_NEXT(a_group_continues, take && !last_beat, valid_q, "group dropped before its last beat")

endmodule

/* hw/rtl/utf8_punctuation_normalizer_unit.sv */
// An accepted beat waits in the input register until the result register is free; then its
// result group is loaded into the result register and shown. Throughput: one input beat per
// cycle while each byte yields at most one result and the master side is ready; a byte that
// yields more results holds the input until the result register has drained them one beat
// per cycle. Reset empties both registers and clears all pending sequence and quote state.
module utf8_punctuation_normalizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [0] byte_valid, [1] text_end
  output logic       m_axis_tlast_o
);

  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  logic          free;
  logic          adv;
  upn_pkg::grp_t grp;

  assign adv             = in_valid_q && free;
  assign s_axis_tready_o = !in_valid_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  upn_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .grp_o     (grp)
  );

  upn_outq u_outq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .grp_i           (grp),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
